// ----- rtl/core/tssc_pkg.sv -----
package tssc_pkg;

  localparam logic [3:0] LAST_DATA_INDEX = 4'd8;
  localparam logic [7:0] CRC_POLY_REFL   = 8'h8C;

  // Resolution settings and their register reset value
  localparam logic [3:0] RES_BITS_9     = 4'd9;
  localparam logic [3:0] RES_BITS_10    = 4'd10;
  localparam logic [3:0] RES_BITS_11    = 4'd11;
  localparam logic [3:0] RES_BITS_RESET = 4'd12;

  // Expected sensor configuration byte per resolution
  localparam logic [7:0] CFG_CODE_9  = 8'h1F;
  localparam logic [7:0] CFG_CODE_10 = 8'h3F;
  localparam logic [7:0] CFG_CODE_11 = 8'h5F;
  localparam logic [7:0] CFG_CODE_12 = 8'h7F;

  localparam logic [15:0] TEMP_MASK_9  = 16'hFFF8;
  localparam logic [15:0] TEMP_MASK_10 = 16'hFFFC;
  localparam logic [15:0] TEMP_MASK_11 = 16'hFFFE;
  localparam logic [15:0] TEMP_MASK_12 = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic               crc_ok;
    logic               resolution_ok;
  } res_item_t;

  // Status of the byte at the head of the frame tracker
  typedef struct packed {
    logic last;   // byte is the CRC byte and yields a result
  } frame_stat_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] temp_mask(input logic [3:0] res);
    logic [15:0] m;
    unique case (res)
      RES_BITS_9:  m = TEMP_MASK_9;
      RES_BITS_10: m = TEMP_MASK_10;
      RES_BITS_11: m = TEMP_MASK_11;
      default:     m = TEMP_MASK_12;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] config_code(input logic [3:0] res);
    logic [7:0] c;
    unique case (res)
      RES_BITS_9:  c = CFG_CODE_9;
      RES_BITS_10: c = CFG_CODE_10;
      RES_BITS_11: c = CFG_CODE_11;
      default:     c = CFG_CODE_12;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/tssc_if.sv -----
interface tssc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tssc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic               crc_ok;
  logic               resolution_ok;

  modport source (output valid, output temperature, output crc_ok, output resolution_ok,
                  input ready);
  modport sink   (input valid, input temperature, input crc_ok, input resolution_ok,
                  output ready);
endinterface

interface tssc_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] resolution_bits;

  modport source (output valid, output resolution_bits, input ready);
  modport sink   (input valid, input resolution_bits, output ready);
endinterface

// ----- rtl/core/tssc_in_reg.sv -----
module tssc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tssc_pkg::in_item_t load_item,
  input  logic              drain,
  output logic              valid,
  output tssc_pkg::in_item_t item
);
  import tssc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // hold while stalled, refill on load
  assign valid_nxt = load | (valid_r & ~drain);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

// ----- rtl/core/tssc_frame.sv -----
module tssc_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  tssc_pkg::in_item_t   item,
  input  logic [3:0]           resolution_bits,
  output tssc_pkg::frame_stat_t stat,
  output tssc_pkg::res_item_t  result
);
  import tssc_pkg::*;

  logic [7:0] crc_r, crc_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [7:0] temp_lo_r, temp_lo_nxt;
  logic [7:0] temp_hi_r, temp_hi_nxt;
  logic [7:0] cfg_byte_r, cfg_byte_nxt;
  logic [3:0] idx_cur;
  logic [7:0] crc_base;
  logic       is_last;

  assign idx_cur  = item.frame_start ? 4'd0 : idx_r;
  assign is_last  = (idx_cur >= LAST_DATA_INDEX);
  assign crc_base = (idx_cur == 4'd0) ? 8'd0 : crc_r;

  always_comb begin
    crc_nxt      = crc_r;
    idx_nxt      = idx_r;
    temp_lo_nxt  = temp_lo_r;
    temp_hi_nxt  = temp_hi_r;
    cfg_byte_nxt = cfg_byte_r;
    if (advance) begin
      if (is_last) begin
        idx_nxt = 4'd0;
      end else begin
        crc_nxt = crc8_update(crc_base, item.data_byte);
        idx_nxt = idx_cur + 4'd1;
        if (idx_cur == 4'd0) temp_lo_nxt  = item.data_byte;
        if (idx_cur == 4'd1) temp_hi_nxt  = item.data_byte;
        if (idx_cur == 4'd4) cfg_byte_nxt = item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= 8'd0;
      idx_r      <= 4'd0;
      temp_lo_r  <= 8'd0;
      temp_hi_r  <= 8'd0;
      cfg_byte_r <= 8'd0;
    end else begin
      crc_r      <= crc_nxt;
      idx_r      <= idx_nxt;
      temp_lo_r  <= temp_lo_nxt;
      temp_hi_r  <= temp_hi_nxt;
      cfg_byte_r <= cfg_byte_nxt;
    end
  end

  assign stat.last = is_last;

  assign result.temperature   = signed'({temp_hi_r, temp_lo_r} & temp_mask(resolution_bits));
  assign result.crc_ok        = (crc_r == item.data_byte);
  assign result.resolution_ok = (cfg_byte_r == config_code(resolution_bits));

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_DATA_INDEX)
    else $error("byte index beyond CRC byte");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_last) |=> (idx_r == 4'd0))
    else $error("byte index did not wrap after CRC byte");
`endif

endmodule

// ----- rtl/core/tssc_out_reg.sv -----
module tssc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tssc_pkg::res_item_t load_item,
  input  logic                take,
  output logic                free,
  output logic                valid,
  output tssc_pkg::res_item_t item
);
  import tssc_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  res_item_t item_r;

  // slot opens when empty or when the receiver takes the request this cycle
  assign free      = ~valid_r | take;
  assign valid_nxt = load | (valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

// ----- rtl/core/temp_sensor_scratchpad_checker.sv -----
// Scratchpad checker for a 1-Wire temperature sensor.
// in_ch   : one scratchpad byte per request (data_byte, frame_start). Send the
//           nine bytes in order; frame_start on a byte marks it as byte 0 and
//           drops any partial frame. After byte 8 the count wraps to byte 0.
// out_ch  : one request per frame, issued on byte 8: resolution-masked raw
//           temperature (1/16 degree), crc_ok (Dallas/Maxim CRC-8 of bytes
//           0..7 against byte 8) and resolution_ok (byte 4 against the code
//           for the configured resolution).
// cfg_ch  : writes resolution_bits (9..12, others act as 12); always ready.
//           Write only while no frame bytes are in flight.
// Timing  : one byte per cycle sustained while no held result blocks a CRC byte.
//           A byte passes an input register, then the CRC/capture logic loads
//           the result register, which drives out_ch.
// Stall   : a held result blocks only a following CRC byte; data bytes 0..7
//           keep flowing into the input register and the CRC logic while the
//           receiver stalls.
// Reset   : rst_n (synchronous, low) clears the CRC, byte count and held
//           bytes to zero, empties both registers and sets resolution to 12.
module temp_sensor_scratchpad_checker (
  input  logic          clk,
  input  logic          rst_n,
  tssc_in_if.sink       in_ch,
  tssc_out_if.source    out_ch,
  tssc_cfg_if.sink      cfg_ch
);
  import tssc_pkg::*;

  logic [3:0]  resolution_r;
  logic [3:0]  resolution_nxt;

  logic        in_load;
  in_item_t    in_item;
  logic        s1_valid;
  in_item_t    s1_item;
  logic        s1_advance;

  frame_stat_t stat;
  res_item_t   result;
  logic        out_load;
  logic        out_free;
  logic        out_valid;
  res_item_t   out_item;

  // resolution register; config port never stalls
  assign cfg_ch.ready   = 1'b1;
  assign resolution_nxt = (cfg_ch.valid) ? cfg_ch.resolution_bits : resolution_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= RES_BITS_RESET;
    end else begin
      resolution_r <= resolution_nxt;
    end
  end

  // advance the head byte unless it is a CRC byte facing a full result slot
  assign s1_advance   = s1_valid & (~stat.last | out_free);
  assign in_ch.ready  = ~s1_valid | s1_advance;
  assign in_load      = in_ch.valid & in_ch.ready;
  assign in_item.data_byte   = in_ch.data_byte;
  assign in_item.frame_start = in_ch.frame_start;
  assign out_load     = s1_advance & stat.last;

  tssc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_load),
    .load_item (in_item),
    .drain     (s1_advance),
    .valid     (s1_valid),
    .item      (s1_item)
  );

  tssc_frame u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (s1_advance),
    .item            (s1_item),
    .resolution_bits (resolution_r),
    .stat            (stat),
    .result          (result)
  );

  tssc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .load_item (result),
    .take      (out_ch.ready),
    .free      (out_free),
    .valid     (out_valid),
    .item      (out_item)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.temperature   = out_item.temperature;
  assign out_ch.crc_ok        = out_item.crc_ok;
  assign out_ch.resolution_ok = out_item.resolution_ok;

`ifndef SYNTH
  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_ch.valid)
    else $error("CRC byte advanced without a result request");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && in_ch.ready))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- test/tb_temp_sensor_scratchpad_checker.sv -----
`timescale 1ns / 100ps

module tb_temp_sensor_scratchpad_checker;
  import tssc_pkg::*;

  // Hang detection: end the run after this many cycles with no request on any channel
  localparam int STALL_LIMIT   = 2000;
  // Let the input and result registers drain before a resolution write or the end
  localparam int SETTLE_CYCLES = 6;
  // Grow each random phase to at least this many scratchpad bytes
  localparam int PHASE_ITEMS   = 100;

  // Scratchpad byte positions that the checker captures
  localparam logic [3:0] IDX_TEMP_LSB = 4'd0;
  localparam logic [3:0] IDX_TEMP_MSB = 4'd1;
  localparam logic [3:0] IDX_CONFIG   = 4'd4;

  // One byte request, plus an optional hand-typed reading for rows that end a frame
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       typed;
    res_item_t  want;
  } byte_req_t;

  // Directed rows: a zero frame right after reset (resolution 12, config byte 0), then
  // a short frame opened by frame_start on a wrapped index, then a frame_start that
  // drops it and opens a full-scale frame checked against the predictor.
  localparam byte_req_t DIRECTED [21] = '{
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{16'sh0000, 1'b1, 1'b0}},
    '{8'hA5, 1'b1, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h5A, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h3C, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h7F, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'hFF, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h10, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '{16'sh0000, 1'b0, 1'b0}}
  };

  // Resolution settings, one per random phase; the last four fall outside 9..12
  localparam logic [3:0] RES_PLAN [8] = '{
    RES_BITS_9, RES_BITS_10, RES_BITS_11, RES_BITS_RESET, 4'd0, 4'd15, 4'd13, 4'd8
  };

  logic clk;
  logic rst_n;

  tssc_in_if  in_ch ();
  tssc_out_if out_ch ();
  tssc_cfg_if cfg_ch ();

  temp_sensor_scratchpad_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state, mirrors the checker after reset
  logic [7:0] crc_acc   = 8'h00;
  logic [3:0] byte_idx  = 4'd0;
  logic [7:0] t_low     = 8'h00;
  logic [7:0] t_high    = 8'h00;
  logic [7:0] cfg_seen  = 8'h00;
  logic [3:0] res_bits  = RES_BITS_RESET;

  byte_req_t byte_q [$];          // byte requests waiting to be driven
  res_item_t pending_readings [$]; // readings the checker still owes
  byte_req_t cur_byte;
  bit        byte_in_flight = 1'b0;
  bit        burst_mode     = 1'b0;
  bit        in_sync        = 1'b1;
  int        fail_count     = 0;
  int        quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Dallas/Maxim CRC-8, shifted one data bit at a time, LSB first
  function automatic logic [7:0] dow_crc8(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[7:1]};
      if (fb) r = r ^ CRC_POLY_REFL;
    end
    return r;
  endfunction

  // Configuration byte the sensor reports at a given resolution; others act as 12
  function automatic logic [7:0] res_code(input logic [3:0] res);
    case (res)
      RES_BITS_9:  return CFG_CODE_9;
      RES_BITS_10: return CFG_CODE_10;
      RES_BITS_11: return CFG_CODE_11;
      default:     return CFG_CODE_12;
    endcase
  endfunction

  // Advance the predictor by one accepted byte; raise done when it closes a frame
  task automatic predict_scratchpad_byte(input logic [7:0] b, input logic fs,
                                         output bit done, output res_item_t r);
    logic [15:0] mask;
    done = 1'b0;
    r    = '0;
    // frame_start forces byte 0 and drops any partial frame
    if (fs) byte_idx = 4'd0;
    if (byte_idx < LAST_DATA_INDEX) begin
      // restart the CRC on every byte 0, with or without frame_start
      if (byte_idx == IDX_TEMP_LSB) crc_acc = 8'h00;
      crc_acc = dow_crc8(crc_acc, b);
      case (byte_idx)
        IDX_TEMP_LSB: t_low    = b;
        IDX_TEMP_MSB: t_high   = b;
        IDX_CONFIG:   cfg_seen = b;
        default: ;
      endcase
      byte_idx = byte_idx + 4'd1;
    end else begin
      case (res_bits)
        RES_BITS_9:  mask = TEMP_MASK_9;
        RES_BITS_10: mask = TEMP_MASK_10;
        RES_BITS_11: mask = TEMP_MASK_11;
        default:     mask = TEMP_MASK_12;
      endcase
      // a bad CRC still yields a full reading, only crc_ok drops
      r.temperature   = {t_high, t_low} & mask;
      r.crc_ok        = (crc_acc == b);
      r.resolution_ok = (cfg_seen == res_code(res_bits));
      byte_idx = 4'd0;
      done     = 1'b1;
    end
  endtask

  // Queue one random chunk: mostly clean frames with random content, the rest
  // short frames cut off by the next frame_start and plain byte noise.
  task automatic queue_random_chunk(inout int n_items);
    byte_req_t  req;
    logic [7:0] frame [9];
    logic [7:0] crc;
    int         kind;
    int         len;
    req  = '0;
    kind = $urandom_range(99);
    if (kind < 72) begin
      for (int k = 0; k < 8; k++) frame[k] = 8'($urandom_range(255));
      // hit the temperature extremes now and then
      case ($urandom_range(7))
        0: {frame[1], frame[0]} = 16'h8000;
        1: {frame[1], frame[0]} = 16'h7FFF;
        2: {frame[1], frame[0]} = 16'hFFFF;
        3: {frame[1], frame[0]} = 16'h0000;
        default: ;
      endcase
      // config byte: matching code, another valid code, or random
      case ($urandom_range(3))
        0, 1: frame[4] = res_code(res_bits);
        2: begin
          case ($urandom_range(3))
            0: frame[4] = CFG_CODE_9;
            1: frame[4] = CFG_CODE_10;
            2: frame[4] = CFG_CODE_11;
            default: frame[4] = CFG_CODE_12;
          endcase
        end
        default: ;
      endcase
      crc = 8'h00;
      for (int k = 0; k < 8; k++) crc = dow_crc8(crc, frame[k]);
      frame[8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : crc;
      for (int k = 0; k < 9; k++) begin
        req.data_byte   = frame[k];
        // resync with frame_start after junk, otherwise rely on the wrap half the time
        req.frame_start = (k == 0) && (!in_sync || $urandom_range(1) == 1);
        byte_q.push_back(req);
      end
      n_items += 9;
      in_sync  = 1'b1;
    end else begin
      len = (kind < 88) ? $urandom_range(8, 1) : $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        req.data_byte   = 8'($urandom_range(255));
        req.frame_start = (kind < 88) ? (k == 0) : ($urandom_range(9) == 0);
        byte_q.push_back(req);
      end
      n_items += len;
      in_sync  = 1'b0;
    end
  endtask

  // Hold until every byte is taken and every reading is back, then let the pipe drain
  task automatic wait_drained();
    while (byte_q.size() != 0 || byte_in_flight || pending_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_resolution(input logic [3:0] v);
    @(posedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.resolution_bits <= v;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    res_bits = v;
  endtask

  // Byte source: hold a request until taken, idle at random between requests
  always @(posedge clk) begin
    bit        done;
    res_item_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_scratchpad_byte(cur_byte.data_byte, cur_byte.frame_start, done, r);
        if (done) pending_readings.push_back(cur_byte.typed ? cur_byte.want : r);
        byte_in_flight = 1'b0;
      end
      if (!byte_in_flight && byte_q.size() != 0 &&
          (burst_mode || $urandom_range(99) >= 18)) begin
        cur_byte       = byte_q.pop_front();
        byte_in_flight = 1'b1;
        in_ch.data_byte   <= cur_byte.data_byte;
        in_ch.frame_start <= cur_byte.frame_start;
      end
      in_ch.valid <= byte_in_flight;
    end
  end

  // Reading sink: stall at random, compare each taken reading with the oldest owed one
  always @(posedge clk) begin
    res_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_readings.size() == 0) begin
          $display("%0t: unexpected reading temperature=%h crc_ok=%b resolution_ok=%b",
                   $time, out_ch.temperature, out_ch.crc_ok, out_ch.resolution_ok);
          fail_count++;
        end else begin
          want = pending_readings.pop_front();
          if (out_ch.temperature !== want.temperature) begin
            $display("%0t: temperature expected %h actual %h",
                     $time, want.temperature, out_ch.temperature);
            fail_count++;
          end
          if (out_ch.crc_ok !== want.crc_ok) begin
            $display("%0t: crc_ok expected %b actual %b", $time, want.crc_ok, out_ch.crc_ok);
            fail_count++;
          end
          if (out_ch.resolution_ok !== want.resolution_ok) begin
            $display("%0t: resolution_ok expected %b actual %b",
                     $time, want.resolution_ok, out_ch.resolution_ok);
            fail_count++;
          end
        end
      end
      out_ch.ready <= burst_mode || ($urandom_range(99) >= 18);
    end
  end

  // Watchdog: count cycles with no request moving on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n_items;
    // drive every input to a known value before the first edge
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.data_byte        = 8'h00;
    in_ch.frame_start      = 1'b0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.resolution_bits = RES_BITS_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows run at the reset resolution
    for (int i = 0; i < 21; i++) byte_q.push_back(DIRECTED[i]);
    wait_drained();

    // one random phase per resolution; phase 3 runs with no idling on either side
    for (int p = 0; p < 8; p++) begin
      write_resolution(RES_PLAN[p]);
      burst_mode = (p == 3);
      n_items    = 0;
      while (n_items < PHASE_ITEMS) queue_random_chunk(n_items);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tssc_pkg.sv
rtl/core/tssc_if.sv
rtl/core/tssc_in_reg.sv
rtl/core/tssc_frame.sv
rtl/core/tssc_out_reg.sv
rtl/core/temp_sensor_scratchpad_checker.sv
test/tb_temp_sensor_scratchpad_checker.sv
